[src/cbb_pkg.sv]
package cbb_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned SIZE_W    = 2;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_BANKS = 8;
  localparam int unsigned LANE_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 3'd0,
    OP_GET     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_COMPACT = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CRD,
    S_CWR,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size_code;
    logic [DATA_W-1:0] write_value;
    logic [CNT_W-1:0]  skip_count;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  readable_bytes;
    logic [CNT_W-1:0]  writable_bytes;
  } rsp_t;

endpackage

[src/cbb_req_if.sv]
interface cbb_req_if import cbb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SIZE_W-1:0]   size_code;
  logic [DATA_W-1:0]   write_value;
  logic [CNT_W-1:0]    skip_count;

  modport source (output valid, output op, output size_code, output write_value,
                  output skip_count, input ready);
  modport sink   (input valid, input op, input size_code, input write_value,
                  input skip_count, output ready);
endinterface

[src/cbb_rsp_if.sv]
interface cbb_rsp_if import cbb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [DATA_W-1:0]   read_value;
  logic [CNT_W-1:0]    readable_bytes;
  logic [CNT_W-1:0]    writable_bytes;

  modport source (output valid, output status, output read_value,
                  output readable_bytes, output writable_bytes, input ready);
  modport sink   (input valid, input status, input read_value,
                  input readable_bytes, input writable_bytes, output ready);
endinterface

[src/cursor_byte_buffer_be_top.sv]
// Linear byte buffer with a read and a write cursor over eight byte-wide memory banks, so
// any run of up to eight consecutive bytes touches each bank at most once. For put, get, peek,
// advance, clear and compact with nothing to move, the banks are read in the cycle the
// request is accepted and the result register is loaded from S_EXEC once the response
// register is free; no new request is accepted until the block is back in S_IDLE. A compact
// that moves data copies eight bytes per pass, reading in S_CRD and writing back in S_CWR,
// and then loads its result in S_FIN. Bytes outside the cursors never reach a result,
// so the banks are not cleared after reset.
module cursor_byte_buffer_be_top import cbb_pkg::*; #(
  parameter int unsigned CAPACITY_BYTES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbb_req_if.sink   req_i,
  cbb_rsp_if.source rsp_o
);

  localparam int unsigned CUR_W  = $clog2(CAPACITY_BYTES + 1);
  localparam int unsigned XW     = ((CUR_W > CNT_W) ? CUR_W : CNT_W) + 1;
  localparam int unsigned ROWS   = (CAPACITY_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int unsigned ROW_W  = $clog2(ROWS + 1);
  localparam int unsigned ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned K_W    = CUR_W - LANE_W + 1;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY_BYTES);

  state_e             state_q, state_d;
  logic [CUR_W-1:0]   rd_q, rd_d, wr_q, wr_d;
  logic [K_W-1:0]     k_q, k_d;
  req_t               req_q;
  rsp_t               out_q, out_d;
  logic               out_valid_q;
  logic               out_load, out_free, accept, put_ok;
  logic [CUR_W-1:0]   readable;
  logic [3:0]         n4;
  logic [LANE_W-1:0]  nm1;
  logic [XW-1:0]      n_x;
  logic [DATA_W-1:0]  asm_rv;
  logic [K_W-1:0]     k_inc;
  logic [CUR_W-1:0]   rpos, wpos;
  logic               mem_re;

  logic [BYTE_W-1:0]    bank_rdata [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign readable = wr_q - rd_q;
  assign n4       = 4'd1 << req_q.size_code;
  assign nm1      = LANE_W'(n4 - 4'd1);
  assign n_x      = XW'(n4);
  assign k_inc    = k_q + 1'b1;

  assign mem_re = accept || (state_q == S_CRD);
  assign rpos   = (state_q == S_CRD) ? rd_q + CUR_W'({k_q, 3'b000}) : rd_q;
  assign wpos   = wr_q;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [LANE_W-1:0] w_lane, src_lane, sh;
    logic [ROW_W-1:0]  r_row, w_row;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [BYTE_W-1:0] wdata;

    assign w_lane = LANE_W'(b) - wpos[LANE_W-1:0];
    assign r_row  = ROW_W'(rpos >> LANE_W)
                    + ROW_W'(LANE_W'(b) < rpos[LANE_W-1:0]);
    assign w_row  = ROW_W'(wpos >> LANE_W)
                    + ROW_W'(LANE_W'(b) < wpos[LANE_W-1:0]);
    assign raddr  = (r_row < ROW_W'(ROWS)) ? ADDR_W'(r_row) : '0;
    assign src_lane = LANE_W'(b) + rd_q[LANE_W-1:0];
    assign sh     = nm1 - w_lane;

    always_comb begin
      if (state_q == S_CWR) begin
        waddr = ADDR_W'(k_q);
        wdata = bank_rdata[src_lane];
      end else begin
        waddr = (w_row < ROW_W'(ROWS)) ? ADDR_W'(w_row) : '0;
        wdata = req_q.write_value[{sh, 3'b000} +: BYTE_W];
      end
    end

    assign bank_we[b] = (state_q == S_CWR)
                        || (put_ok && ({1'b0, w_lane} < n4));

    cbb_bank #(.ROWS(ROWS), .ADDR_W(ADDR_W)) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (mem_re),
      .raddr_i (raddr),
      .rdata_o (bank_rdata[b])
    );
  end

  always_comb begin
    logic [LANE_W-1:0] lane, sh;
    asm_rv = '0;
    for (int i = 0; i < NUM_BANKS; i++) begin
      lane = rd_q[LANE_W-1:0] + LANE_W'(i);
      sh   = nm1 - LANE_W'(i);
      if (4'(i) < n4) begin
        asm_rv[{sh, 3'b000} +: BYTE_W] = bank_rdata[lane];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    k_d      = k_q;
    out_load = 1'b0;
    put_ok   = 1'b0;
    out_d.status     = ST_OK;
    out_d.read_value = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          case (req_q.op)
            OP_PUT: begin
              if (XW'(wr_q) + n_x > CAP_X) begin
                out_d.status = ST_EXHAUSTED;
              end else begin
                put_ok = 1'b1;
                wr_d   = wr_q + CUR_W'(n4);
              end
            end
            OP_GET, OP_PEEK: begin
              if (XW'(readable) < n_x) begin
                out_d.status = ST_INVALID;
              end else begin
                out_d.read_value = asm_rv;
                if (req_q.op == OP_GET) begin
                  rd_d = rd_q + CUR_W'(n4);
                end
              end
            end
            OP_ADVANCE: begin
              if (XW'(req_q.skip_count) > XW'(readable)) begin
                out_d.status = ST_INVALID;
              end else begin
                rd_d = rd_q + CUR_W'(req_q.skip_count);
              end
            end
            OP_COMPACT: begin
              if (rd_q != '0) begin
                if (readable == '0) begin
                  rd_d = '0;
                  wr_d = '0;
                end else begin
                  out_load = 1'b0;
                  k_d      = '0;
                  state_d  = S_CRD;
                end
              end
            end
            OP_CLEAR: begin
              rd_d = '0;
              wr_d = '0;
            end
            default: begin
              out_d.status = ST_INVALID;
            end
          endcase
        end
      end
      S_CRD: begin
        state_d = S_CWR;
      end
      S_CWR: begin
        k_d = k_inc;
        if (XW'({k_inc, 3'b000}) >= XW'(readable)) begin
          rd_d    = '0;
          wr_d    = readable;
          state_d = S_FIN;
        end else begin
          state_d = S_CRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_d.readable_bytes = CNT_W'(XW'(wr_d) - XW'(rd_d));
    out_d.writable_bytes = CNT_W'(CAP_X - XW'(wr_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.op          <= req_i.op;
      req_q.size_code   <= req_i.size_code;
      req_q.write_value <= req_i.write_value;
      req_q.skip_count  <= req_i.skip_count;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.read_value     = out_q.read_value;
  assign rsp_o.readable_bytes = out_q.readable_bytes;
  assign rsp_o.writable_bytes = out_q.writable_bytes;

  a_cursor_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= wr_q)
    else $error("read cursor passed write cursor");

  a_cursor_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(wr_q) <= CAP_X)
    else $error("write cursor passed capacity");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> (rsp_o.read_value == '0))
    else $error("failed request carries a nonzero value");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted request not executed next cycle");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (bank_we == '0))
    else $error("bank write while idle");

endmodule

[src/cbb_bank.sv]
module cbb_bank import cbb_pkg::*; #(
  parameter int unsigned ROWS   = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  logic [BYTE_W-1:0]   wdata_i,
  input  logic                re_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output logic [BYTE_W-1:0]   rdata_o
);

  logic [BYTE_W-1:0] mem_q [ROWS];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
